### hdl/glcm_pkg.sv
package glcm_pkg;

  // Datapath operations, one per microinstruction
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_GCD_INIT,
    OP_GCD_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_MUL_DONE,
    OP_EMIT
  } dp_op_t;

  // Branch conditions: taken -> target, else fall through
  typedef enum logic [2:0] {
    BR_NEVER,
    BR_ALWAYS,
    BR_OVF,
    BR_GCD_BUSY,
    BR_CNT_BUSY
  } br_t;

  // Hold conditions: the step repeats without effect until released
  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_IDLE     = 4'd0;
  localparam upc_t UPC_GCD_INIT = 4'd1;
  localparam upc_t UPC_GCD_STEP = 4'd2;
  localparam upc_t UPC_DIV_INIT = 4'd3;
  localparam upc_t UPC_DIV_STEP = 4'd4;
  localparam upc_t UPC_MUL_INIT = 4'd5;
  localparam upc_t UPC_MUL_STEP = 4'd6;
  localparam upc_t UPC_MUL_DONE = 4'd7;
  localparam upc_t UPC_EMIT     = 4'd8;

  typedef struct packed {
    dp_op_t op;
    wait_t  wait_on;
    br_t    br;
    upc_t   target;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    dp_op_t op;
    logic   fire;
    logic   take_in;
  } dp_ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic ovf;
    logic gcd_busy;
    logic cnt_busy;
    logic out_busy;
  } dp_stat_t;

  // Microprogram
  function automatic uword_t ucode_rom(upc_t addr);
    uword_t w;
    case (addr)
      UPC_IDLE:     w = '{OP_LOAD,     WAIT_IN,   BR_OVF,      UPC_EMIT};
      UPC_GCD_INIT: w = '{OP_GCD_INIT, WAIT_NONE, BR_NEVER,    UPC_IDLE};
      UPC_GCD_STEP: w = '{OP_GCD_STEP, WAIT_NONE, BR_GCD_BUSY, UPC_GCD_STEP};
      UPC_DIV_INIT: w = '{OP_DIV_INIT, WAIT_NONE, BR_NEVER,    UPC_IDLE};
      UPC_DIV_STEP: w = '{OP_DIV_STEP, WAIT_NONE, BR_CNT_BUSY, UPC_DIV_STEP};
      UPC_MUL_INIT: w = '{OP_MUL_INIT, WAIT_NONE, BR_NEVER,    UPC_IDLE};
      UPC_MUL_STEP: w = '{OP_MUL_STEP, WAIT_NONE, BR_CNT_BUSY, UPC_MUL_STEP};
      UPC_MUL_DONE: w = '{OP_MUL_DONE, WAIT_NONE, BR_NEVER,    UPC_IDLE};
      UPC_EMIT:     w = '{OP_EMIT,     WAIT_OUT,  BR_ALWAYS,   UPC_IDLE};
      default:      w = '{OP_NOP,      WAIT_NONE, BR_ALWAYS,   UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/group_lcm_accumulator.sv
// Group LCM accumulator.
// Input channel (item_valid / item_stall): one word per group member, with
// value and last_in_group. A zero value counts as 1.
// Output channel (result_valid / result_stall): one word per group, sent
// after the word flagged last_in_group: lcm and overflow. On overflow lcm
// is all ones and later values of that group are skipped.
// Each value is folded in as cur * (value / gcd(cur, value)) by a small
// microprogram: binary gcd (one step per cycle), restoring division and
// shift-add multiply (one bit per cycle each) on one shared datapath.
// One word is in work at a time; item_stall is low only in the idle step.
// result_valid is registered and rises once the emit step for the last
// word has run (straight after the idle step if overflowed), after any
// wait on an old result.
// Reset (rst, synchronous) empties the group: running lcm 1, no overflow,
// no result pending. The output word sits in a register; a stalled
// receiver holds it, and the next word of a new group is still taken and
// worked on; the sequencer only waits when a second result is ready.
module group_lcm_accumulator
  import glcm_pkg::*;
#(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   last_in_group,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [VALUE_WIDTH-1:0] lcm,
  output logic                   overflow
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // microcode sequencer: step counter, ROM, branch/hold logic
  glcm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .stat       (stat),
    .ctl        (ctl)
  );

  // gcd / divide / multiply datapath with running result and output reg
  glcm_dp #(
    .W (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .value         (value),
    .last_in_group (last_in_group),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .lcm           (lcm),
    .overflow      (overflow)
  );

  // input taken only in the idle microinstruction
  assign item_stall = !ctl.take_in;

endmodule

### hdl/glcm_seq.sv
module glcm_seq
  import glcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   hold;
  logic   taken;

  assign uw = ucode_rom(upc);

  always_comb begin
    case (uw.wait_on)
      WAIT_IN:  hold = !item_valid;
      WAIT_OUT: hold = stat.out_busy;
      default:  hold = 1'b0;
    endcase

    case (uw.br)
      BR_NEVER:    taken = 1'b0;
      BR_ALWAYS:   taken = 1'b1;
      BR_OVF:      taken = stat.ovf;
      BR_GCD_BUSY: taken = stat.gcd_busy;
      BR_CNT_BUSY: taken = stat.cnt_busy;
      default:     taken = 1'b0;
    endcase

    if (hold) begin
      upc_next = upc;
    end else if (taken) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + 1'b1;
    end

    ctl.op      = uw.op;
    ctl.fire    = !hold;
    ctl.take_in = (uw.wait_on == WAIT_IN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

### hdl/glcm_dp.sv
module glcm_dp
  import glcm_pkg::*;
#(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  dp_ctl_t      ctl,
  output dp_stat_t     stat,
  input  logic [W-1:0] value,
  input  logic         last_in_group,
  input  logic         result_stall,
  output logic         result_valid,
  output logic [W-1:0] lcm,
  output logic         overflow
);

  localparam int CW = $clog2(W);
  localparam logic [W-1:0]  MASK     = '1;
  localparam logic [W-1:0]  ONE      = W'(1);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic [W-1:0]  cur;
  logic          ovf_seen;
  logic [W-1:0]  vin;
  logic          last_r;
  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [W:0]    acc;
  logic [CW-1:0] k;
  logic [CW-1:0] cnt;

  logic          gcd_busy;
  logic          cnt_busy;
  logic [W-1:0]  a_minus_b;
  logic [W-1:0]  b_minus_a;
  logic [W-1:0]  g;
  logic [W:0]    div_r;
  logic          div_fit;
  logic [W:0]    div_diff;
  logic [W:0]    mul_sum;
  logic          emit;

  always_comb begin
    gcd_busy  = (a != '0) && (b != '0);
    cnt_busy  = (cnt != CNT_LAST);
    a_minus_b = a - b;
    b_minus_a = b - a;
    g         = (a | b) << k;
    // restoring division: shift dividend bit into partial remainder
    div_r     = {acc[W-1:0], a[W-1]};
    div_fit   = (div_r >= {1'b0, b});
    div_diff  = div_r - {1'b0, b};
    // shift-add multiply: acc is the high half, a the multiplier/low half
    mul_sum   = {1'b0, acc[W-1:0]} + {1'b0, (a[0] ? b : {W{1'b0}})};
    emit      = ctl.fire && (ctl.op == OP_EMIT) && last_r;

    stat.ovf      = ovf_seen;
    stat.gcd_busy = gcd_busy;
    stat.cnt_busy = cnt_busy;
    stat.out_busy = last_r && result_valid && result_stall;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      case (ctl.op)
        OP_LOAD: begin
          vin    <= (value == '0) ? ONE : value;
          last_r <= last_in_group;
        end
        OP_GCD_INIT: begin
          a <= cur;
          b <= vin;
          k <= '0;
        end
        OP_GCD_STEP: begin
          if (gcd_busy) begin
            if (!a[0] && !b[0]) begin
              a <= a >> 1;
              b <= b >> 1;
              k <= k + 1'b1;
            end else if (!a[0]) begin
              a <= a >> 1;
            end else if (!b[0]) begin
              b <= b >> 1;
            end else if (a >= b) begin
              a <= a_minus_b >> 1;
            end else begin
              b <= b_minus_a >> 1;
            end
          end
        end
        OP_DIV_INIT: begin
          b   <= g;
          a   <= vin;
          acc <= '0;
          cnt <= '0;
        end
        OP_DIV_STEP: begin
          a   <= {a[W-2:0], div_fit};
          acc <= div_fit ? div_diff : div_r;
          cnt <= cnt + 1'b1;
        end
        OP_MUL_INIT: begin
          b   <= cur;
          acc <= '0;
          cnt <= '0;
        end
        OP_MUL_STEP: begin
          acc <= {1'b0, mul_sum[W:1]};
          a   <= {mul_sum[0], a[W-1:1]};
          cnt <= cnt + 1'b1;
        end
        OP_EMIT: begin
          if (last_r) begin
            lcm      <= cur;
            overflow <= ovf_seen;
          end
        end
        default: ;
      endcase
    end
  end

  // running result and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cur          <= ONE;
      ovf_seen     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (ctl.fire) begin
        case (ctl.op)
          OP_MUL_DONE: begin
            if (acc[W-1:0] != '0) begin
              cur      <= MASK;
              ovf_seen <= 1'b1;
            end else begin
              cur <= a;
            end
          end
          OP_EMIT: begin
            if (last_r) begin
              cur      <= ONE;
              ovf_seen <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_cur_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur != '0)
    else $error("running lcm is zero");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    ovf_seen |-> (cur == MASK))
    else $error("overflow set but running lcm not saturated");

  a_out_saturated: assert property (@(posedge clk) disable iff (rst)
    (result_valid && overflow) |-> (lcm == MASK))
    else $error("overflow word without saturated lcm");

  a_emit_restarts: assert property (@(posedge clk) disable iff (rst)
    emit |=> (cur == ONE && !ovf_seen && result_valid))
    else $error("group did not restart after emit");

endmodule
